// File: rtl/core/sdp_pkg.sv
// Package for the signed density pseudocolour map: constants, register codes,
// the flag group passed between pipeline sections and the sine table builder.
// No dependencies.
package sdp_pkg;

  localparam int SAMPLE_W        = 32;
  localparam int LIM_W           = 32;
  localparam int PROD_W          = 48;
  localparam int SCALE_FRAC      = 8;
  localparam int SINE_TABLE_BITS = 8;

  localparam logic [30:0] MAX_VALUE_RST     = 31'd65536;
  localparam logic [31:0] MIN_VALUE_RST     = 32'hFFFF_0000;
  localparam logic [15:0] CONTOUR_SCALE_RST = 16'd2560;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [1:0] {
    CFG_MAX_VALUE     = 2'd0,
    CFG_MIN_VALUE     = 2'd1,
    CFG_CONTOUR_SCALE = 2'd2
  } cfg_index_t;

  // neg: sample below zero; sat: level clipped at full scale; zero: level forced to 0
  typedef struct packed {
    logic neg;
    logic sat;
    logic zero;
  } sdp_flags_t;

  // shift-and-subtract quotient of two 64-bit values; table building only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(255 * sin(pi * idx / 2^stb)) for idx up to the quarter wave, built with a
  // Q30 Taylor series through x^15; evaluated at elaboration only
  function automatic logic [7:0] sine_entry(int unsigned idx, int unsigned stb);
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] byte_v;
    logic [63:0] dv;
    int          k;
    if (idx == 0) begin
      return 8'd0;
    end
    if (idx >= (32'd1 << (stb - 1))) begin
      return 8'd255;
    end
    theta = (PI_Q30 * 64'(idx)) >> stb;
    x2    = (theta * theta) >> 30;
    acc   = Q30_ONE;
    for (k = 7; k >= 1; k--) begin
      dv  = 64'((2 * k) * (2 * k + 1));
      acc = Q30_ONE - udiv64((x2 * acc) >> 30, dv);
    end
    s      = (theta * acc) >> 30;
    byte_v = (64'd255 * s) >> 30;
    if (byte_v > 64'd255) begin
      byte_v = 64'd255;
    end
    return byte_v[7:0];
  endfunction

endpackage

// File: rtl/core/signed_density_pseudocolor.sv
// Channel   Handshake            Payload
// input     in_valid / in_stall  sample (32, signed Q16.16)
// output    out_valid / out_stall red, green, blue (8 each)
// config    cfg_valid / cfg_ready cfg_index (2), cfg_data (32)
//
// One sample per cycle unless a stalled output has filled the pipe; a result passes through
// the front section, the divider (one quotient bit per stage) and the colour section.
// Synchronous reset restores the three registers and empties every stage.
// A stalled output holds; upstream stages keep filling bubbles until all are full.
// Top level: register file and pipeline sections; depends on sdp_pkg, sdp_front,
// sdp_div and sdp_color.
module signed_density_pseudocolor
  import sdp_pkg::*;
#(
  parameter int STB = SINE_TABLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int RW = LIM_W + STB;

  logic [30:0]      max_value;
  logic [31:0]      min_value;
  logic [15:0]      contour_scale;

  logic             fd_valid;
  logic             fd_stall;
  logic [RW-1:0]    fd_rem;
  logic [LIM_W-1:0] fd_lim;
  sdp_flags_t       fd_flags;
  logic             dc_valid;
  logic             dc_stall;
  logic [STB-1:0]   dc_quo;
  sdp_flags_t       dc_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value     <= MAX_VALUE_RST;
      min_value     <= MIN_VALUE_RST;
      contour_scale <= CONTOUR_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_VALUE:     max_value     <= cfg_data[30:0];
        CFG_MIN_VALUE:     min_value     <= cfg_data;
        CFG_CONTOUR_SCALE: contour_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sdp_front #(.STB(STB)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .max_value    (max_value),
    .min_value    (min_value),
    .contour_scale(contour_scale),
    .out_valid    (fd_valid),
    .out_stall    (fd_stall),
    .out_rem      (fd_rem),
    .out_lim      (fd_lim),
    .out_flags    (fd_flags)
  );

  sdp_div #(.STB(STB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fd_valid),
    .in_stall (fd_stall),
    .in_rem   (fd_rem),
    .in_lim   (fd_lim),
    .in_flags (fd_flags),
    .out_valid(dc_valid),
    .out_stall(dc_stall),
    .out_quo  (dc_quo),
    .out_flags(dc_flags)
  );

  sdp_color #(.STB(STB)) u_color (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dc_valid),
    .in_stall (dc_stall),
    .in_quo   (dc_quo),
    .in_flags (dc_flags),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

`ifndef NO_ASSERTIONS
  // every colour on the map has one channel at full brightness
  a_one_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == 8'd255 || green == 8'd255 || blue == 8'd255))
    else $error("result has no full channel");

  // red and blue are never lit together
  a_red_blue: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == 8'd0 || blue == 8'd0))
    else $error("result mixes red and blue");

  // back-pressure reaches the input only once the output is held
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");
`endif

endmodule

// File: rtl/core/sdp_front.sv
// Front section: sample magnitude and limit select, scale multiply, then the
// saturation test and dividend alignment. Three register stages.
// Depends on sdp_pkg.
module sdp_front
  import sdp_pkg::*;
#(
  parameter int STB = SINE_TABLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic [30:0]           max_value,
  input  logic [31:0]           min_value,
  input  logic [15:0]           contour_scale,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LIM_W+STB-1:0]  out_rem,
  output logic [LIM_W-1:0]      out_lim,
  output sdp_flags_t            out_flags
);

  localparam int RW = LIM_W + STB;
  localparam int NW = PROD_W + STB;

  logic                a_valid;
  logic                a_neg;
  logic [SAMPLE_W-1:0] a_mag;
  logic [LIM_W-1:0]    a_lim;
  logic                b_valid;
  logic                b_neg;
  logic [PROD_W-1:0]   b_prod;
  logic [LIM_W-1:0]    b_lim;
  logic                c_valid;
  logic [RW-1:0]       c_rem;
  logic [LIM_W-1:0]    c_lim;
  sdp_flags_t          c_flags;

  logic                en_a;
  logic                en_b;
  logic                en_c;
  logic                s_neg;
  logic [SAMPLE_W-1:0] s_mag;
  logic [LIM_W-1:0]    s_lim;
  logic [NW-1:0]       num_full;
  logic [NW-1:0]       num_shift;
  sdp_flags_t          flags_next;

  assign en_c     = !c_valid || !out_stall;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_stall = !en_a;

  // the most negative sample negates onto itself, which is the right magnitude
  assign s_neg = sample[SAMPLE_W-1];
  assign s_mag = s_neg ? (~sample + SAMPLE_W'(1)) : sample;
  always_comb begin
    if (!s_neg) begin
      s_lim = {1'b0, max_value};
    end else if (min_value[31]) begin
      s_lim = ~min_value + LIM_W'(1);
    end else begin
      s_lim = '0;
    end
  end

  assign num_full  = {b_prod, {STB{1'b0}}};
  assign num_shift = num_full >> SCALE_FRAC;

  always_comb begin
    flags_next.neg  = b_neg;
    flags_next.sat  = b_prod >= PROD_W'({b_lim, {SCALE_FRAC{1'b0}}});
    flags_next.zero = (b_lim == '0) || (b_prod == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= in_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_neg <= s_neg;
      a_mag <= s_mag;
      a_lim <= s_lim;
    end
    if (en_b) begin
      b_neg  <= a_neg;
      b_prod <= PROD_W'(a_mag) * PROD_W'(contour_scale);
      b_lim  <= a_lim;
    end
    if (en_c) begin
      c_rem   <= num_shift[RW-1:0];
      c_lim   <= b_lim;
      c_flags <= flags_next;
    end
  end

  assign out_valid = c_valid;
  assign out_rem   = c_rem;
  assign out_lim   = c_lim;
  assign out_flags = c_flags;

endmodule

// File: rtl/core/sdp_div.sv
// Pipelined restoring divider: one quotient bit per register stage, STB stages.
// The dividend is known to be below lim * 2^STB unless the level saturated.
// Depends on sdp_pkg.
module sdp_div
  import sdp_pkg::*;
#(
  parameter int STB = SINE_TABLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LIM_W+STB-1:0]  in_rem,
  input  logic [LIM_W-1:0]      in_lim,
  input  sdp_flags_t            in_flags,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STB-1:0]        out_quo,
  output sdp_flags_t            out_flags
);

  localparam int RW = LIM_W + STB;

  logic             v   [STB];
  logic             en  [STB];
  logic [STB-1:0]   quo [STB];
  sdp_flags_t       flg [STB];
  logic [RW-1:0]    rem [STB-1];
  logic [LIM_W-1:0] lim [STB-1];

  for (genvar j = 0; j < STB; j++) begin : g_stage
    logic             v_in;
    logic [RW-1:0]    rem_in;
    logic [LIM_W-1:0] lim_in;
    logic [STB-1:0]   quo_in;
    sdp_flags_t       flg_in;
    logic [RW-1:0]    dsr;
    logic             take;

    if (j == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_rem;
      assign lim_in = in_lim;
      assign quo_in = '0;
      assign flg_in = in_flags;
    end else begin : g_next
      assign v_in   = v[j-1];
      assign rem_in = rem[j-1];
      assign lim_in = lim[j-1];
      assign quo_in = quo[j-1];
      assign flg_in = flg[j-1];
    end

    if (j == STB - 1) begin : g_last_en
      assign en[j] = !v[j] || !out_stall;
    end else begin : g_mid_en
      assign en[j] = !v[j] || en[j+1];
    end

    assign dsr  = RW'(lim_in) << (STB - 1 - j);
    assign take = rem_in >= dsr;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        quo[j] <= take ? (quo_in | (STB'(1) << (STB - 1 - j))) : quo_in;
        flg[j] <= flg_in;
      end
    end

    // the last stage needs neither remainder nor divisor
    if (j < STB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem[j] <= take ? (rem_in - dsr) : rem_in;
          lim[j] <= lim_in;
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[STB-1];
  assign out_quo   = quo[STB-1];
  assign out_flags = flg[STB-1];

endmodule

// File: rtl/core/sdp_color.sv
// Colour section: level and segment select, then sine table read and channel
// assembly into the output register. Two register stages.
// Depends on sdp_pkg.
module sdp_color
  import sdp_pkg::*;
#(
  parameter int STB = SINE_TABLE_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [STB-1:0] in_quo,
  input  sdp_flags_t     in_flags,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue
);

  localparam int HALF = 1 << (STB - 1);
  localparam int FULL = 1 << STB;
  localparam logic [STB:0] HALF_L = (STB + 1)'(HALF);
  localparam logic [STB:0] FULL_L = (STB + 1)'(FULL);

  typedef enum logic [1:0] {
    SEG_BLUE_CYAN,
    SEG_CYAN_GREEN,
    SEG_GREEN_YELLOW,
    SEG_YELLOW_RED
  } segment_t;

  logic [7:0]     sine_rom [HALF+1];

  for (genvar g = 0; g <= HALF; g++) begin : g_rom
    localparam logic [7:0] ENTRY = sine_entry(g, STB);
    assign sine_rom[g] = ENTRY;
  end

  logic           d_valid;
  logic [STB-1:0] d_idx;
  segment_t       d_seg;
  logic           en_d;
  logic           en_e;
  logic [STB:0]   lvl;
  logic [STB:0]   mirror;
  logic [STB-1:0] idx_next;
  segment_t       seg_next;
  logic [7:0]     sn;
  logic [7:0]     red_next;
  logic [7:0]     green_next;
  logic [7:0]     blue_next;

  assign en_e     = !out_valid || !out_stall;
  assign en_d     = !d_valid || en_e;
  assign in_stall = !en_d;

  always_comb begin
    if (in_flags.zero) begin
      lvl = '0;
    end else if (in_flags.sat) begin
      lvl = FULL_L;
    end else begin
      lvl = {1'b0, in_quo};
    end
  end

  // fold the upper half of the wave onto the quarter-wave table
  assign mirror   = FULL_L - lvl;
  assign idx_next = (lvl <= HALF_L) ? lvl[STB-1:0] : mirror[STB-1:0];

  always_comb begin
    if (in_flags.neg && (lvl > HALF_L)) begin
      seg_next = SEG_BLUE_CYAN;
    end else if (in_flags.neg && (lvl != '0)) begin
      seg_next = SEG_CYAN_GREEN;
    end else if (lvl < HALF_L) begin
      seg_next = SEG_GREEN_YELLOW;
    end else begin
      seg_next = SEG_YELLOW_RED;
    end
  end

  assign sn = sine_rom[d_idx];

  always_comb begin
    unique case (d_seg)
      SEG_BLUE_CYAN: begin
        red_next   = 8'd0;
        green_next = sn;
        blue_next  = 8'd255;
      end
      SEG_CYAN_GREEN: begin
        red_next   = 8'd0;
        green_next = 8'd255;
        blue_next  = sn;
      end
      SEG_GREEN_YELLOW: begin
        red_next   = sn;
        green_next = 8'd255;
        blue_next  = 8'd0;
      end
      SEG_YELLOW_RED: begin
        red_next   = 8'd255;
        green_next = sn;
        blue_next  = 8'd0;
      end
      default: begin
        red_next   = 8'd0;
        green_next = 8'd255;
        blue_next  = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_d) begin
        d_valid <= in_valid;
      end
      if (en_e) begin
        out_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_idx <= idx_next;
      d_seg <= seg_next;
    end
    if (en_e) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking bench for signed_density_pseudocolor: an in-bench predictor of the jet-style
// colour map, random bursty requests and stalls, register phases. Depends on sdp_pkg and the RTL.
module tb_top
  import sdp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LATENCY        = SINE_TABLE_BITS + 5;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 300;
  localparam logic [1:0]  CFG_UNUSED     = 2'd3;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  class pixel_board;
    localparam int FULL = 1 << SINE_TABLE_BITS;
    localparam int HALF = 1 << (SINE_TABLE_BITS - 1);

    rgb_t        colour_q[$];
    logic [30:0] max_v;
    logic [31:0] min_v;
    logic [15:0] cscale;
    logic [7:0]  sine_lut [0:HALF];
    int          errors;

    function new();
      logic [63:0] ang;
      logic [63:0] ang2;
      logic [63:0] acc;
      logic [63:0] s;
      logic [63:0] lvl8;
      max_v  = MAX_VALUE_RST;
      min_v  = MIN_VALUE_RST;
      cscale = CONTOUR_SCALE_RST;
      errors = 0;
      // quarter-wave table, Q30 Taylor series through x^15
      for (int i = 0; i <= HALF; i++) begin
        ang  = (PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
        ang2 = (ang * ang) >> 30;
        acc  = Q30_ONE;
        for (int k = 7; k >= 1; k--) begin
          acc = Q30_ONE - (((ang2 * acc) >> 30) / 64'((2 * k) * (2 * k + 1)));
        end
        s    = (ang * acc) >> 30;
        lvl8 = (64'd255 * s) >> 30;
        if (lvl8 > 64'd255) begin
          lvl8 = 64'd255;
        end
        sine_lut[i] = (i == 0) ? 8'd0 : ((i >= HALF) ? 8'd255 : lvl8[7:0]);
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_MAX_VALUE:     max_v  = data[30:0];
        CFG_MIN_VALUE:     min_v  = data;
        CFG_CONTOUR_SCALE: cscale = data[15:0];
        default: ;
      endcase
    endfunction

    // a non-negative minimum counts as no limit at all
    function logic [63:0] limit_for(logic neg);
      if (neg) begin
        return min_v[31] ? (64'h1_0000_0000 - {32'd0, min_v}) : 64'd0;
      end
      return {33'd0, max_v};
    endfunction

    function int pending();
      return colour_q.size();
    endfunction

    function void note_sample(logic [31:0] raw);
      logic        neg;
      logic [31:0] negr;
      logic [63:0] mag;
      logic [63:0] lim;
      logic [63:0] lvl;
      int unsigned idx;
      logic [7:0]  sn;
      rgb_t        px;
      neg  = raw[31];
      negr = -raw;
      mag  = neg ? {32'd0, negr} : {32'd0, raw};
      lim  = limit_for(neg);
      lvl  = 64'd0;
      if (lim != 0 && mag != 0 && cscale != 0) begin
        lvl = ((mag * {48'd0, cscale}) << SINE_TABLE_BITS) / (lim << SCALE_FRAC);
        if (lvl > 64'(FULL)) begin
          lvl = 64'(FULL);
        end
      end
      idx = 32'((lvl <= 64'(HALF)) ? lvl : (64'(FULL) - lvl));
      sn  = sine_lut[idx];
      if (neg && lvl > HALF) begin
        px = {8'd0, sn, 8'd255};
      end else if (neg && lvl != 0) begin
        px = {8'd0, 8'd255, sn};
      end else if (lvl < HALF) begin
        px = {sn, 8'd255, 8'd0};
      end else begin
        px = {8'd255, sn, 8'd0};
      end
      colour_q.push_back(px);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) begin
        $display("tb: mismatch at %0t: %s", $time, msg);
      end
    endtask

    task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t want;
      if (colour_q.size() == 0) begin
        report($sformatf("pixel %0d/%0d/%0d with no request pending", r, g, b));
        return;
      end
      want = colour_q.pop_front();
      if (r !== want.r) report($sformatf("red %0d, predicted %0d", r, want.r));
      if (g !== want.g) report($sformatf("green %0d, predicted %0d", g, want.g));
      if (b !== want.b) report($sformatf("blue %0d, predicted %0d", b, want.b));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] sample;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  pixel_board sb;
  int         burst_left;
  int         hold_asked;
  int         hold_done;
  int         hold_left;
  int         rx_mode;
  int         rx_mode_left;
  int         rx_cyc;
  int         quiet;

  logic [31:0] edge_samples [0:23] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd25, 32'd26, -32'sd26,
    32'd1638, -32'sd1638, 32'd3276, 32'd3277, -32'sd3276, -32'sd3277,
    32'd3328, -32'sd3328, 32'd6553, 32'd6554, -32'sd6553, -32'sd6554,
    32'd65536, -32'sd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0000_FFFF
  };

  signed_density_pseudocolor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // request and result monitor; registers follow every accepted write
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_pixel(red, green, blue);
      end
      if (in_valid && !in_stall) begin
        sb.note_sample(sample);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cyc++;
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(16, 128);
        end
        rx_mode_left--;
        case (rx_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= (rx_cyc % 3 == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [31:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(1, 12);
        default: gap = 1;
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= s;
    // stall is settled by the falling edge; the request goes at the next rising one
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] mx, input logic [31:0] mn,
                              input logic [31:0] cs, input bit poke_unused);
    logic [1:0]  idx;
    logic [31:0] d;
    for (int i = 0; i < (poke_unused ? 4 : 3); i++) begin
      case (i)
        0:       begin idx = CFG_MAX_VALUE;     d = mx;      end
        1:       begin idx = CFG_MIN_VALUE;     d = mn;      end
        2:       begin idx = CFG_CONTOUR_SCALE; d = cs;      end
        default: begin idx = CFG_UNUSED;        d = $urandom; end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      do @(negedge clk); while (!cfg_ready);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // mostly levels aimed around the segment edges, the rest raw noise and extremes
  function automatic logic [31:0] pick_sample();
    int unsigned pick;
    logic        neg;
    logic [63:0] lim;
    logic [63:0] mag;
    logic [31:0] m32;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return $urandom;
    end
    if (pick < 30) begin
      case ($urandom_range(0, 6))
        0:       return 32'h0000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h8000_0000;
        3:       return 32'h0000_0001;
        4:       return 32'hFFFF_FFFF;
        default: begin
          m32 = $urandom_range(0, 255);
          return $urandom_range(0, 1) ? -m32 : m32;
        end
      endcase
    end
    neg = $urandom_range(0, 1);
    lim = sb.limit_for(neg);
    if (lim == 0 || sb.cscale == 0) begin
      mag = {32'd0, $urandom >> $urandom_range(0, 31)};
    end else begin
      mag = (64'($urandom_range(0, 300)) * lim) / {48'd0, sb.cscale} + 64'($urandom_range(0, 2));
      if (mag != 0) begin
        mag = mag - 1;
      end
    end
    if (mag > 64'h7FFF_FFFF + neg) begin
      mag = 64'h7FFF_FFFF + neg;
    end
    m32 = mag[31:0];
    return neg ? -m32 : m32;
  endfunction

  initial begin
    sb           = new();
    burst_left   = 0;
    hold_asked   = 0;
    hold_done    = 0;
    hold_left    = 0;
    rx_mode      = 0;
    rx_mode_left = 0;
    rx_cyc       = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample    <= 32'd0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAX_VALUE;
    cfg_data  <= 32'd0;
    quiet     <= 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: ;
        1: program_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_FFFF, 1'b0);
        2: program_regs(32'h0000_0001, 32'hFFFF_FFFF, 32'hABCD_0001, 1'b0);
        3: program_regs(32'h8000_0000, 32'h0000_0000, 32'h0000_0100, 1'b1);
        4: program_regs(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        5: program_regs($urandom >> 4, 32'h0000_0005, $urandom_range(1, 65535), 1'b0);
        default: program_regs($urandom >> $urandom_range(0, 24),
                              -($urandom >> $urandom_range(1, 24)),
                              $urandom >> $urandom_range(0, 16), ph == 8);
      endcase
      if (ph == 0) begin
        for (int e = 0; e < 24; e++) begin
          send_sample(edge_samples[e]);
        end
      end
      // hold the receiver off while requests keep coming, so the pipe fills
      if (ph == 1 || ph == 7) begin
        hold_asked++;
      end
      repeat (80) send_sample(pick_sample());
      in_valid <= 1'b0;
      wait_drain();
    end

    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d predicted pixels never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
